FILE: hdl/l2vn_pkg.sv
// Shared constants and types for the L2 vector normalizer.
package l2vn_pkg;

  localparam int MAX_ELEMENTS = 4096;
  localparam int SAMPLE_BITS  = 16;
  localparam int ADDR_W       = 12;
  localparam int LEN_W        = 13;
  localparam int SUM_W        = 43;
  localparam int MAG_W        = SAMPLE_BITS + 1;
  localparam int SQ_W         = 2 * SAMPLE_BITS - 1;
  localparam int IN_TDATA_W   = 32;
  localparam int OUT_TDATA_W  = 16;
  localparam int BIT_W        = 4;
  // search datapath widths
  localparam int P_W          = 63;
  localparam int Q_W          = 64;
  localparam int T_W          = 82;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_FETCH  = 4'b0010,
    ST_SEARCH = 4'b0100,
    ST_EMIT   = 4'b1000
  } l2vn_state_t;

endpackage

FILE: hdl/l2vn_ram.sv
// Generic single-port synchronous RAM with registered read data.
module l2vn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/l2_vector_normalizer.sv
// L2 vector normalizer top level: element store, square sum and bitwise rounding search.
//
//   channel  dir  handshake          tdata                         tuser  tlast
//   in_      in   in_tvalid/tready   [15:0] value, [27:16] index   kind   last
//   out_     out  out_tvalid/tready  [15:0] component              in_range  -
//
// A load is absorbed in the idle state; loads may arrive back to back.
// A read passes address, fetch, 16 search steps (one result bit each) and emit; a zero
// element or sum skips the search, and an out-of-range read also skips the fetch.
// Reset clears length, sum and completion; the store holds no reset value.
// A read waits in its emit cycle while the previous result is not yet taken.
module l2_vector_normalizer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [l2vn_pkg::IN_TDATA_W-1:0]  in_tdata,  // [15:0] value, [27:16] index
  input  logic                             in_tuser,  // kind
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [l2vn_pkg::OUT_TDATA_W-1:0] out_tdata, // [15:0] component
  output logic                             out_tuser  // in_range
);
  import l2vn_pkg::*;

  l2vn_state_t             state_r, state_nxt;
  logic [LEN_W-1:0]        len_r, len_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic                    done_r, done_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0]  out_data_r, out_data_nxt;
  logic                    out_rng_r, out_rng_nxt;
  logic                    rng_r, rng_nxt;
  logic                    zero_r, zero_nxt;
  logic                    neg_r, neg_nxt;
  logic [SQ_W-1:0]         asq_r, asq_nxt;
  logic [P_W-1:0]          p_r, p_nxt;
  logic signed [Q_W-1:0]   q_r, q_nxt;
  logic [SAMPLE_BITS-1:0]  res_r, res_nxt;
  logic [BIT_W-1:0]        bit_r, bit_nxt;

  logic                    in_acc, ld, rd;
  logic signed [SAMPLE_BITS-1:0] in_value;
  logic [ADDR_W-1:0]       in_index;
  logic [LEN_W-1:0]        len_base;
  logic [SUM_W-1:0]        sum_base;
  logic                    store_ok;
  logic signed [MAG_W-1:0] ld_vx, rd_vx;
  logic [MAG_W-1:0]        ld_mag, rd_mag;
  logic [2*MAG_W-1:0]      ld_sq, rd_sq;
  logic                    rng_ok;

  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_addr;
  logic [SAMPLE_BITS-1:0]  ram_rdata;

  logic signed [T_W-1:0]   p_ext, q_ext, s_ext, t_q, t_s, trial, a_lim;
  logic [5:0]              sh_q, sh_s;
  logic [Q_W-1:0]          s64;
  logic                    reach;
  logic [SAMPLE_BITS-1:0]  comp;
  logic                    slot_free;

  assign in_acc   = in_tvalid & in_tready;
  assign ld       = in_acc & (in_tuser == KIND_LOAD);
  assign rd       = in_acc & (in_tuser == KIND_READ);
  assign in_value = in_tdata[SAMPLE_BITS-1:0];
  assign in_index = in_tdata[SAMPLE_BITS +: ADDR_W];
  assign in_tready = (state_r == ST_IDLE);

  // a load onto a complete vector starts a new one
  assign len_base = done_r ? '0 : len_r;
  assign sum_base = done_r ? '0 : sum_r;
  assign store_ok = (len_base < LEN_W'(MAX_ELEMENTS));

  assign ld_vx  = {in_value[SAMPLE_BITS-1], in_value};
  assign ld_mag = ld_vx[MAG_W-1] ? MAG_W'(-ld_vx) : MAG_W'(ld_vx);
  assign ld_sq  = ld_mag * ld_mag;

  assign rd_vx  = {ram_rdata[SAMPLE_BITS-1], ram_rdata};
  assign rd_mag = rd_vx[MAG_W-1] ? MAG_W'(-rd_vx) : MAG_W'(rd_vx);
  assign rd_sq  = rd_mag * rd_mag;

  assign rng_ok = done_r && ({1'b0, in_index} < len_r);

  assign ram_we   = ld & store_ok;
  assign ram_addr = ld ? len_base[ADDR_W-1:0] : in_index;

  l2vn_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_ELEMENTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_value),
    .rdata (ram_rdata)
  );

  // Greedy bit search for the largest r with (2r-1)^2 * S <= a^2 * 2^32.
  // P = d^2*S and Q = d*S (d = 2r-1) are updated by shifts and adds only.
  assign sh_q  = 6'(bit_r) + 6'd2;
  assign sh_s  = {1'b0, bit_r, 1'b0} + 6'd2;
  assign p_ext = {{(T_W-P_W){1'b0}}, p_r};
  assign q_ext = {{(T_W-Q_W){q_r[Q_W-1]}}, q_r};
  assign s_ext = {{(T_W-SUM_W){1'b0}}, sum_r};
  assign t_q   = q_ext <<< sh_q;
  assign t_s   = s_ext <<< sh_s;
  assign trial = p_ext + t_q + t_s;
  assign a_lim = {{(T_W-SQ_W-32){1'b0}}, asq_r, 32'b0};
  assign reach = (trial <= a_lim);
  assign s64   = {{(Q_W-SUM_W){1'b0}}, sum_r};

  assign comp = zero_r ? '0 :
                neg_r  ? SAMPLE_BITS'(-res_r) :
                res_r[SAMPLE_BITS-1] ? {1'b0, {(SAMPLE_BITS-1){1'b1}}} : res_r;

  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    sum_nxt       = sum_r;
    done_nxt      = done_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_rng_nxt   = out_rng_r;
    rng_nxt       = rng_r;
    zero_nxt      = zero_r;
    neg_nxt       = neg_r;
    asq_nxt       = asq_r;
    p_nxt         = p_r;
    q_nxt         = q_r;
    res_nxt       = res_r;
    bit_nxt       = bit_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (ld) begin
          len_nxt  = store_ok ? len_base + LEN_W'(1) : len_base;
          sum_nxt  = store_ok ? sum_base + SUM_W'(ld_sq[SQ_W-1:0]) : sum_base;
          done_nxt = in_tlast;
        end else if (rd) begin
          rng_nxt   = rng_ok;
          zero_nxt  = 1'b1;
          state_nxt = rng_ok ? ST_FETCH : ST_EMIT;
        end
      end
      ST_FETCH: begin
        neg_nxt = ram_rdata[SAMPLE_BITS-1];
        asq_nxt = rd_sq[SQ_W-1:0];
        p_nxt   = P_W'(sum_r);
        q_nxt   = -$signed(s64);
        res_nxt = '0;
        bit_nxt = BIT_W'(SAMPLE_BITS - 1);
        if (ram_rdata == '0 || sum_r == '0) begin
          zero_nxt  = 1'b1;
          state_nxt = ST_EMIT;
        end else begin
          zero_nxt  = 1'b0;
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (reach) begin
          res_nxt = res_r | (SAMPLE_BITS'(1) << bit_r);
          p_nxt   = trial[P_W-1:0];
          q_nxt   = q_r + $signed(s64 << (7'(bit_r) + 7'd1));
        end
        bit_nxt = bit_r - BIT_W'(1);
        if (bit_r == '0) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = comp;
          out_rng_nxt   = rng_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      sum_r       <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      sum_r       <= sum_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
    out_rng_r  <= out_rng_nxt;
    rng_r      <= rng_nxt;
    zero_r     <= zero_nxt;
    neg_r      <= neg_nxt;
    asq_r      <= asq_nxt;
    p_r        <= p_nxt;
    q_r        <= q_nxt;
    res_r      <= res_nxt;
    bit_r      <= bit_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_rng_r;

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(MAX_ELEMENTS))
    else $error("vector length beyond store depth");

  a_read_path: assert property (@(posedge clk) disable iff (!rst_n)
    rd |=> (state_r == ST_FETCH || state_r == ST_EMIT))
    else $error("read transaction did not enter fetch or emit");

  a_elem_in_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |-> (SUM_W'(asq_r) <= sum_r))
    else $error("element square exceeds square sum");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("result raised outside emit");
`endif

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for l2_vector_normalizer with a local predictor.
`timescale 1ns / 1ps

module testbench;
  import l2vn_pkg::*;

  localparam int FULL_SCALE = 1 << (SAMPLE_BITS - 1);

  typedef struct packed {
    logic [15:0] component;
    logic        in_range;
  } norm_result_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  // predictor state
  logic signed [15:0] elem_copy[MAX_ELEMENTS];
  int unsigned        vec_len;
  logic [63:0]        sq_sum;
  bit                 vec_done;

  norm_result_t expected_q[$];
  int error_count;
  int items_sent;
  int send_idle_pct;
  int recv_stall_pct;

  l2_vector_normalizer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Nearest integer to x * 2^15 / sqrt(S), ties away from zero, by bisection on
  // the exact test (2r-1)^2 * S <= x^2 * 2^32.
  function automatic logic [15:0] unit_scale(logic signed [15:0] x);
    int xi;
    longint unsigned mag;
    int lo, hi, mid;
    logic [127:0] lhs, rhs, dd;
    xi = int'(x);
    mag = 64'((xi < 0) ? -xi : xi);
    if (sq_sum == 0 || mag == 0) return '0;
    lo = 0;
    hi = FULL_SCALE;
    rhs = 128'(mag * mag) << (2 * SAMPLE_BITS);
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      dd = 128'(2 * mid - 1);
      lhs = dd * dd * 128'(sq_sum);
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    if (xi >= 0) begin
      if (lo > FULL_SCALE - 1) lo = FULL_SCALE - 1;
      return 16'(lo);
    end
    return 16'(-lo);
  endfunction

  function automatic void predict(logic kind, logic [15:0] value, logic is_last,
                                  logic [11:0] idx);
    norm_result_t r;
    longint sq;
    if (kind == KIND_LOAD) begin
      if (vec_done) begin
        vec_len = 0;
        sq_sum = '0;
        vec_done = 0;
      end
      if (vec_len < MAX_ELEMENTS) begin
        elem_copy[vec_len] = value;
        sq = longint'($signed(value)) * longint'($signed(value));
        sq_sum += 64'(sq);
        vec_len++;
      end
      if (is_last) vec_done = 1;
    end else begin
      if (vec_done && idx < vec_len) begin
        r.component = unit_scale(elem_copy[idx]);
        r.in_range = 1'b1;
      end else begin
        r = '0;
      end
      expected_q.push_back(r);
    end
  endfunction

  task automatic send_item(logic kind, logic [15:0] value, logic is_last, logic [11:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tlast <= is_last;
    in_tdata <= {4'b0, idx, value};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict(kind, value, is_last, idx);
    items_sent++;
  endtask

  task automatic load_element(logic [15:0] value, logic is_last);
    send_item(KIND_LOAD, value, is_last, 12'($urandom));
  endtask

  task automatic read_element(logic [11:0] idx);
    send_item(KIND_READ, 16'($urandom), 1'($urandom), idx);
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'(int'($urandom_range(510)) - 255);
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // receiver side
  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin : check_results
    norm_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, got component %0d in_range %b",
                 $time, $signed(out_tdata), out_tuser);
        error_count++;
      end else begin
        want = expected_q.pop_front();
        if (out_tdata !== want.component) begin
          $display("%0t: component mismatch, expected %0d got %0d", $time,
                   $signed(want.component), $signed(out_tdata));
          error_count++;
        end
        if (out_tuser !== want.in_range) begin
          $display("%0t: in_range mismatch, expected %b got %b", $time,
                   want.in_range, out_tuser);
          error_count++;
        end
      end
    end
  end

  task automatic test_empty_reads();
    read_element(12'd0);
    read_element(12'hFFF);
  endtask

  task automatic test_saturation();
    load_element(16'h7FFF, 1'b1);
    read_element(12'd0);
    load_element(16'h0001, 1'b1);
    read_element(12'd0);
    load_element(16'h8000, 1'b1);
    read_element(12'd0);
    read_element(12'd1);
  endtask

  task automatic test_zero_vector();
    load_element(16'h0000, 1'b0);
    load_element(16'h0000, 1'b1);
    read_element(12'd0);
    read_element(12'd1);
    read_element(12'd2);
  endtask

  task automatic test_pending_read();
    load_element(16'd3, 1'b0);
    read_element(12'd0);  // not complete yet
    load_element(-16'sd4, 1'b1);
    read_element(12'd0);
    read_element(12'd1);
    read_element(12'hFFF);
  endtask

  // S = 2^34, so each element scales by exactly 1/4: halves land on ties
  task automatic test_rounding_ties();
    load_element(16'd2, 1'b0);
    load_element(16'd2, 1'b0);
    load_element(16'd4, 1'b0);
    load_element(-16'sd6, 1'b0);
    load_element(-16'sd18, 1'b0);
    load_element(16'd1448, 1'b0);
    for (int i = 0; i < 16; i++)
      load_element((i % 2) ? -16'sd32766 : 16'sd32766, i == 15);
    for (int i = 0; i < 8; i++) read_element(12'(i));
  endtask

  task automatic test_random_phase(int n_items, int idle_pct, int stall_pct);
    int start, len, reads, pick;
    bit zeros;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    start = items_sent;
    while (items_sent - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        // complete vector followed by reads
        case ($urandom_range(19))
          0: len = $urandom_range(65, 300);
          1, 2, 3, 4, 5: len = $urandom_range(9, 64);
          default: len = $urandom_range(1, 8);
        endcase
        zeros = ($urandom_range(19) == 0);
        for (int i = 0; i < len; i++) begin
          load_element(zeros ? 16'h0000 : pick_value(), i == len - 1);
          if ($urandom_range(29) == 0) read_element(12'($urandom_range(len - 1)));
        end
        reads = $urandom_range(1, 6);
        for (int i = 0; i < reads; i++) begin
          if ($urandom_range(4) == 0) read_element(12'($urandom));
          else read_element(12'($urandom_range(vec_len - 1)));
        end
      end else if (pick < 90) begin
        read_element(12'($urandom));
      end else begin
        // partial vector, reads while incomplete
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) load_element(pick_value(), 1'b0);
        read_element(12'($urandom_range(7)));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    in_tlast = 1'b0;
    vec_len = 0;
    sq_sum = '0;
    vec_done = 0;
    error_count = 0;
    items_sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_reads();
    test_saturation();
    test_zero_vector();
    test_pending_read();
    test_rounding_ties();
    test_random_phase(375, 0, 0);
    test_random_phase(375, 59, 0);
    test_random_phase(375, 0, 59);
    test_random_phase(375, 24, 24);

    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
